@@ sv/sgmpca_pkg.sv @@
package sgmpca_pkg;

    // path_kind codes
    localparam logic [1:0] PK_ROW  = 2'd0;
    localparam logic [1:0] PK_COL  = 2'd1;
    localparam logic [1:0] PK_DIAG = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PATH_KIND  = 3'd0;
    localparam logic [2:0] REG_SMALL_PEN  = 3'd1;
    localparam logic [2:0] REG_LARGE_PEN  = 3'd2;
    localparam logic [2:0] REG_DISP_COUNT = 3'd3;
    localparam logic [2:0] REG_ROW_LENGTH = 3'd4;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    // descriptor fields sized for the largest supported geometry
    localparam int COL_W  = 12;
    localparam int DISP_W = 8;

    localparam logic [15:0] ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  path_kind;
        logic [9:0]  small_penalty;
        logic [9:0]  large_penalty;
        logic [6:0]  disparity_count;
        logic [10:0] row_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        cost;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  pcol;
        logic [DISP_W-1:0] disp;
        logic              bank;
        logic              pbank;
        logic              boundary;
        logic              last;
        logic              minus_ok;
        logic              plus_ok;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ sv/sgmpca_in_if.sv @@
interface sgmpca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] match_cost;
    logic       frame_start;

    modport source (output valid, output match_cost, output frame_start, input ready);
    modport sink   (input valid, input match_cost, input frame_start, output ready);
endinterface

@@ sv/sgmpca_out_if.sv @@
interface sgmpca_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] path_cost;
    logic [5:0]  disparity_index;
    logic        pixel_done;

    modport source (output valid, output path_cost, output disparity_index,
                    output pixel_done, input ready);
    modport sink   (input valid, input path_cost, input disparity_index,
                    input pixel_done, output ready);
endinterface

@@ sv/sgm_path_cost_aggregation_core.sv @@
// channel   dir  handshake     payload
// i_cost    in   valid/ready   match_cost[7:0], frame_start
// o_path    out  valid/ready   path_cost[15:0], disparity_index[5:0], pixel_done
// cfg       in   i_cfg_we      i_cfg_idx[2:0], i_cfg_data[10:0]
//
// One cost per cycle sustained while the output is not stalled; a request passes
// through the queue, the cost-memory read and the compute into the output register.
// Synchronous active-low reset clears counters, queue and valids; the
// cost and minima memories are not cleared (read only after being written).
// Rows alternate between two memory banks, so no copy at row end.
// A stalled output holds the back end; the two-entry queue keeps input open until it fills.
module sgm_path_cost_aggregation_core #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_DISPARITIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgmpca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgmpca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sgmpca_in_if.sink                          i_cost,
    sgmpca_out_if.source                       o_path
);
    import sgmpca_pkg::*;

    t_cfg          r_cfg;
    t_desc         push_desc, pop_desc;
    t_queue_status q_status;
    logic          push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.path_kind       <= PK_ROW;
            r_cfg.small_penalty   <= 10'd10;
            r_cfg.large_penalty   <= 10'd120;
            r_cfg.disparity_count <= 7'd64;
            r_cfg.row_length      <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PATH_KIND:  r_cfg.path_kind       <= i_cfg_data[1:0];
                REG_SMALL_PEN:  r_cfg.small_penalty   <= i_cfg_data[9:0];
                REG_LARGE_PEN:  r_cfg.large_penalty   <= i_cfg_data[9:0];
                REG_DISP_COUNT: r_cfg.disparity_count <= i_cfg_data[6:0];
                REG_ROW_LENGTH: r_cfg.row_length      <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    sgmpca_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_DISPARITIES (MAX_DISPARITIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .s_in    (i_cost),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    sgmpca_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_desc   (pop_desc),
        .o_status (q_status)
    );

    sgmpca_back #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_DISPARITIES (MAX_DISPARITIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_desc   (pop_desc),
        .i_status (q_status),
        .o_pop    (pop),
        .m_out    (o_path)
    );
endmodule

@@ sv/sgmpca_front.sv @@
module sgmpca_front #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_DISPARITIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sgmpca_pkg::t_cfg     i_cfg,
    sgmpca_in_if.sink            s_in,
    input  logic                 i_full,
    output logic                 o_push,
    output sgmpca_pkg::t_desc    o_desc
);
    import sgmpca_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW  = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
    localparam int DCW = $clog2(MAX_DISPARITIES + 1) + 1;
    localparam int RLW = $clog2(MAX_WIDTH + 1) + 1;

    logic [CW-1:0]  r_col, n_col;
    logic [DW-1:0]  r_d, n_d;
    logic           r_first, n_first;
    logic           r_bank, n_bank;

    logic [CW-1:0]  col, pcol;
    logic [DW-1:0]  d;
    logic           first, boundary, last, row_end, pbank;
    logic [DCW-1:0] dc, d_inc;
    logic [RLW-1:0] rl, col_inc;

    assign s_in.ready = !i_full;
    assign o_push     = s_in.valid && !i_full;

    always_comb begin
        if (i_cfg.disparity_count == 7'd0) begin
            dc = DCW'(1);
        end else if (DCW'(i_cfg.disparity_count) > DCW'(MAX_DISPARITIES)) begin
            dc = DCW'(MAX_DISPARITIES);
        end else begin
            dc = DCW'(i_cfg.disparity_count);
        end
        if (i_cfg.row_length == 11'd0) begin
            rl = RLW'(1);
        end else if (RLW'(i_cfg.row_length) > RLW'(MAX_WIDTH)) begin
            rl = RLW'(MAX_WIDTH);
        end else begin
            rl = RLW'(i_cfg.row_length);
        end
    end

    always_comb begin
        col     = s_in.frame_start ? '0 : r_col;
        d       = s_in.frame_start ? '0 : r_d;
        first   = s_in.frame_start ? 1'b1 : r_first;
        d_inc   = DCW'(d) + DCW'(1);
        col_inc = RLW'(col) + RLW'(1);
        last    = d_inc >= dc;
        row_end = col_inc >= rl;
        pcol    = col - CW'(col != '0);
        pbank   = ~r_bank;
        unique case (i_cfg.path_kind)
            PK_ROW: begin
                boundary = (col == '0);
                pbank    = r_bank;
            end
            PK_COL: begin
                boundary = first;
                pcol     = col;
            end
            PK_DIAG: boundary = first || (col == '0);
            default: boundary = 1'b1;
        endcase
    end

    always_comb begin
        o_desc.cost     = s_in.match_cost;
        o_desc.col      = COL_W'(col);
        o_desc.pcol     = COL_W'(pcol);
        o_desc.disp     = DISP_W'(d);
        o_desc.bank     = r_bank;
        o_desc.pbank    = pbank;
        o_desc.boundary = boundary;
        o_desc.last     = last;
        o_desc.minus_ok = (d != '0);
        o_desc.plus_ok  = !last;
    end

    always_comb begin
        n_col   = r_col;
        n_d     = r_d;
        n_first = r_first;
        n_bank  = r_bank;
        if (o_push) begin
            n_first = first;
            n_col   = col;
            if (last) begin
                n_d = '0;
                if (row_end) begin
                    n_col   = '0;
                    n_first = 1'b0;
                    n_bank  = ~r_bank;
                end else begin
                    n_col = CW'(col_inc);
                end
            end else begin
                n_d = DW'(d_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_d     <= '0;
            r_first <= 1'b1;
            r_bank  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_d     <= n_d;
            r_first <= n_first;
            r_bank  <= n_bank;
        end
    end
endmodule

@@ sv/sgmpca_queue.sv @@
module sgmpca_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  sgmpca_pkg::t_desc          i_desc,
    input  logic                       i_pop,
    output sgmpca_pkg::t_desc          o_desc,
    output sgmpca_pkg::t_queue_status  o_status
);
    import sgmpca_pkg::*;

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_desc         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

@@ sv/sgmpca_back.sv @@
module sgmpca_back #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_DISPARITIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sgmpca_pkg::t_cfg           i_cfg,
    input  sgmpca_pkg::t_desc          i_desc,
    input  sgmpca_pkg::t_queue_status  i_status,
    output logic                       o_pop,
    sgmpca_out_if.source               m_out
);
    import sgmpca_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int OFFW = $clog2(MAX_WIDTH * MAX_DISPARITIES);
    localparam int AW   = OFFW + 1;
    localparam int MW   = CW + 1;

    logic [15:0] r_cost_mem [2**AW];
    logic [15:0] r_min_mem  [2**MW];

    t_desc       r_c;
    logic        r_c_valid;
    logic [15:0] r_rd_a, r_rd_b, r_rd_m, r_prev_a, r_runmin;
    logic        r_o_valid;
    logic [15:0] r_o_cost;
    logic [5:0]  r_o_d;
    logic        r_o_done;

    logic          c_adv;
    logic [AW-1:0] addr_a, addr_b, addr_w;
    logic [MW-1:0] maddr_r, maddr_w;
    logic          min_we;
    logic [15:0]   minus, plus, other, best, result, m;

    assign c_adv = r_c_valid && (!r_o_valid || m_out.ready);
    assign o_pop = !i_status.empty && (!r_c_valid || c_adv);

    always_comb begin
        addr_a  = {i_desc.pbank,
                   OFFW'(32'(i_desc.pcol) * MAX_DISPARITIES + 32'(i_desc.disp))};
        addr_b  = {i_desc.pbank,
                   OFFW'(32'(i_desc.pcol) * MAX_DISPARITIES + 32'(i_desc.disp) + 32'd1)};
        addr_w  = {r_c.bank, OFFW'(32'(r_c.col) * MAX_DISPARITIES + 32'(r_c.disp))};
        maddr_r = {i_desc.pbank, CW'(i_desc.pcol)};
        maddr_w = {r_c.bank, CW'(r_c.col)};
        min_we  = c_adv && r_c.last;
    end

    always_comb begin
        minus  = r_c.minus_ok ? r_prev_a + 16'(i_cfg.small_penalty) : ALL_ONES;
        plus   = r_c.plus_ok ? r_rd_b + 16'(i_cfg.small_penalty) : ALL_ONES;
        other  = r_rd_m + 16'(i_cfg.large_penalty);
        best   = r_rd_a;
        if (minus < best) begin
            best = minus;
        end
        if (plus < best) begin
            best = plus;
        end
        if (other < best) begin
            best = other;
        end
        result = r_c.boundary ? 16'(r_c.cost) : 16'(r_c.cost) + best - r_rd_m;
        m      = (r_c.disp == '0 || result < r_runmin) ? result : r_runmin;
    end

    // write-through on a same-cycle write keeps the neighbour reads current
    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_cost_mem[addr_w] <= result;
        end
        if (o_pop) begin
            r_rd_a <= (c_adv && addr_w == addr_a) ? result : r_cost_mem[addr_a];
            r_rd_b <= (c_adv && addr_w == addr_b) ? result : r_cost_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (min_we) begin
            r_min_mem[maddr_w] <= m;
        end
        if (o_pop) begin
            r_rd_m <= (min_we && maddr_w == maddr_r) ? m : r_min_mem[maddr_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c <= i_desc;
        end
        if (c_adv) begin
            r_prev_a <= r_rd_a;
            r_o_cost <= result;
            r_o_d    <= 6'(r_c.disp);
            r_o_done <= r_c.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_runmin  <= ALL_ONES;
        end else begin
            if (o_pop) begin
                r_c_valid <= 1'b1;
            end else if (c_adv) begin
                r_c_valid <= 1'b0;
            end
            if (c_adv) begin
                r_o_valid <= 1'b1;
                r_runmin  <= r_c.last ? ALL_ONES : m;
            end else if (m_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign m_out.valid           = r_o_valid;
    assign m_out.path_cost       = r_o_cost;
    assign m_out.disparity_index = r_o_d;
    assign m_out.pixel_done      = r_o_done;
endmodule

@@ sv/sgmpca_checker.sv @@
module sgmpca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_path_cost,
    input logic [5:0]  i_disp,
    input logic        i_done
);
    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // reset empties the queue, so input opens right away
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_path_cost) && $stable(i_disp) && $stable(i_done))
        else $error("stalled result changed");
endmodule

bind sgm_path_cost_aggregation_core sgmpca_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cost.ready),
    .i_out_valid (o_path.valid),
    .i_out_ready (o_path.ready),
    .i_path_cost (o_path.path_cost),
    .i_disp      (o_path.disparity_index),
    .i_done      (o_path.pixel_done)
);

@@ tb/sgm_path_cost_aggregation_core_tb.sv @@
`timescale 1ns / 100ps

module sgm_path_cost_aggregation_core_tb;
    import sgmpca_pkg::*;

    class path_cost_scoreboard;
        typedef struct {
            bit [15:0] path_cost;
            bit [5:0]  disp;
            bit        done;
        } t_path_rec;

        t_path_rec pending[$];
        int        errors;

        bit [1:0]  kind;
        bit [9:0]  p1;
        bit [9:0]  p2;
        bit [6:0]  dcnt;
        bit [10:0] rlen;

        // two row banks; "cur" is the row being written
        bit [15:0] costs[2][65536];
        bit [15:0] minima[2][1024];
        bit        cur;
        bit [15:0] run_min;
        int        col;
        int        d;
        bit        first_row;

        function new();
            kind      = PK_ROW;
            p1        = 10;
            p2        = 120;
            dcnt      = 64;
            rlen      = 1024;
            cur       = 0;
            run_min   = ALL_ONES;
            col       = 0;
            d         = 0;
            first_row = 1;
            errors    = 0;
        endfunction

        function void set_reg(bit [2:0] idx, bit [10:0] v);
            case (idx)
                REG_PATH_KIND:  kind = v[1:0];
                REG_SMALL_PEN:  p1   = v[9:0];
                REG_LARGE_PEN:  p2   = v[9:0];
                REG_DISP_COUNT: dcnt = v[6:0];
                REG_ROW_LENGTH: rlen = v[10:0];
                default: ;
            endcase
        endfunction

        function bit [15:0] min2(bit [15:0] a, bit [15:0] b);
            return (a < b) ? a : b;
        endfunction

        function void note_request(bit [7:0] mc, bit fs);
            int        dn;
            int        rn;
            int        pcol;
            bit        boundary;
            bit        pb;
            bit [15:0] res;
            bit [15:0] minp;
            bit [15:0] same;
            bit [15:0] minus;
            bit [15:0] plus;
            bit [15:0] other;
            bit [15:0] best;
            bit [15:0] m;
            t_path_rec r;
            dn = (dcnt < 1) ? 1 : ((dcnt > 64) ? 64 : dcnt);
            rn = (rlen < 1) ? 1 : ((rlen > 1024) ? 1024 : rlen);
            if (fs) begin
                col       = 0;
                d         = 0;
                first_row = 1;
                run_min   = ALL_ONES;
            end
            pb   = cur;
            pcol = (col > 0) ? col - 1 : 0;
            case (kind)
                PK_ROW: begin
                    boundary = (col == 0);
                end
                PK_COL: begin
                    boundary = first_row;
                    pb       = !cur;
                    pcol     = col;
                end
                PK_DIAG: begin
                    boundary = first_row || (col == 0);
                    pb       = !cur;
                end
                default: boundary = 1;
            endcase
            if (boundary) begin
                res = mc;
            end else begin
                minp  = minima[pb][pcol];
                same  = costs[pb][pcol*64 + d];
                minus = ALL_ONES;
                plus  = ALL_ONES;
                other = minp + p2;
                if (d > 0)
                    minus = costs[pb][pcol*64 + d - 1] + p1;
                if (d + 1 < dn)
                    plus = costs[pb][pcol*64 + d + 1] + p1;
                best = min2(same, min2(min2(minus, plus), other));
                res  = mc + best - minp;
            end
            costs[cur][col*64 + d] = res;
            m = (d == 0) ? res : min2(run_min, res);
            r.path_cost = res;
            r.disp      = d[5:0];
            r.done      = (d + 1 >= dn);
            pending.insert(pending.size(), r);
            if (r.done) begin
                minima[cur][col] = m;
                run_min = ALL_ONES;
                d = 0;
                if (col + 1 >= rn) begin
                    cur       = !cur;
                    col       = 0;
                    first_row = 0;
                end else begin
                    col++;
                end
            end else begin
                run_min = m;
                d++;
            end
        endfunction

        function void check_result(bit [15:0] pc, bit [5:0] di, bit pd);
            t_path_rec r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result cost=%0d disp=%0d done=%0d", $time, pc, di, pd);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (pc !== r.path_cost) begin
                $display("%0t: path_cost expected %0d actual %0d", $time, r.path_cost, pc);
                errors++;
            end
            if (di !== r.disp) begin
                $display("%0t: disparity_index expected %0d actual %0d", $time, r.disp, di);
                errors++;
            end
            if (pd !== r.done) begin
                $display("%0t: pixel_done expected %0d actual %0d", $time, r.done, pd);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sgmpca_in_if  cost_if();
    sgmpca_out_if path_if();

    sgm_path_cost_aggregation_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cost     (cost_if.sink),
        .o_path     (path_if.source)
    );

    path_cost_scoreboard sb = new();

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;
    int total_sent;
    int phase_no;

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("sgm_path_cost_aggregation_core_tb failed");
        $finish;
    end

    // receiver side
    initial begin
        path_if.ready <= 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (path_if.valid && path_if.ready)
                sb.check_result(path_if.path_cost, path_if.disparity_index, path_if.pixel_done);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                path_if.ready <= 0;
            end else begin
                path_if.ready <= (i_rst_n && $urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_cost(bit [7:0] mc, bit fs);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            cost_if.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge i_clk);
        end
        cost_if.valid       <= 1;
        cost_if.match_cost  <= mc;
        cost_if.frame_start <= fs;
        @(posedge i_clk);
        while (!cost_if.ready)
            @(posedge i_clk);
        sb.note_request(mc, fs);
        total_sent++;
    endtask

    task automatic write_reg(bit [2:0] idx, bit [10:0] v);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic wait_drained();
        cost_if.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic bit [7:0] pick_cost();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // each phase starts a new frame under one register setting
    task automatic run_phase(bit [1:0] kind, bit [9:0] pen1, bit [9:0] pen2,
                             bit [6:0] dc, bit [10:0] rl, int n);
        wait_drained();
        write_reg(REG_PATH_KIND, kind);
        write_reg(REG_SMALL_PEN, pen1);
        write_reg(REG_LARGE_PEN, pen2);
        write_reg(REG_DISP_COUNT, dc);
        write_reg(REG_ROW_LENGTH, rl);
        i_cfg_we <= 0;
        @(posedge i_clk);
        case (phase_no % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
        endcase
        phase_no++;
        for (int k = 0; k < n; k++)
            send_cost(pick_cost(), (k == 0) || ($urandom_range(0, 199) == 0));
    endtask

    initial begin
        bit [1:0] rk;
        bit [6:0] rd;
        bit [10:0] rr;
        int       rn;
        i_rst_n             <= 0;
        i_cfg_we            <= 0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        cost_if.valid       <= 0;
        cost_if.match_cost  <= '0;
        cost_if.frame_start <= 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req   = 0;
        total_sent = 0;
        phase_no   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: diagonal, three rows of two pixels, extreme costs
        wait_drained();
        write_reg(REG_PATH_KIND, PK_DIAG);
        write_reg(REG_DISP_COUNT, 7'd3);
        write_reg(REG_ROW_LENGTH, 11'd2);
        i_cfg_we <= 0;
        for (int k = 0; k < 18; k++)
            send_cost((k % 3 == 1) ? 8'd0 : 8'd255, k == 0);
        send_cost(8'd200, 1);

        // long receiver hold once the second phase starts sending
        fork
            begin
                wait (phase_no == 2);
                hold_req = 1;
            end
        join_none

        // extremes of the settings, clamped counts among them
        run_phase(PK_ROW, 10'd0, 10'd0, 7'd1, 11'd1024, 120);
        run_phase(PK_COL, 10'd1023, 10'd1023, 7'd64, 11'd2, 192);
        run_phase(PK_DIAG, 10'd1023, 10'd0, 7'd127, 11'd1, 130);
        run_phase(PK_COL, 10'd5, 10'd1023, 7'd0, 11'd2047, 40);
        run_phase(2'd3, 10'd512, 10'd256, 7'd4, 11'd3, 30);
        run_phase(PK_DIAG, 10'd0, 10'd1023, 7'd2, 11'd1, 20);

        while (total_sent < 1050) begin
            rk = 2'($urandom_range(0, 3));
            rd = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(1, 64))
                                              : 7'($urandom_range(1, 6));
            rr = 11'($urandom_range(1, 6));
            rn = rd * rr * $urandom_range(2, 5) + $urandom_range(0, rd);
            if (rn > 300) rn = 300;
            run_phase(rk, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      rd, rr, rn);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("sgm_path_cost_aggregation_core_tb passed");
        end else begin
            $display("sgm_path_cost_aggregation_core_tb failed");
        end
        $finish;
    end
endmodule
